// ===== sv/hsv_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv_pkg: shared types and constants of the HSV to RGB converter
// Holds the hue field width, the divide unit stage enables and sector codes.
// ----------------------------------------------------------------------------
package hsv_pkg;

	localparam int unsigned HUE_W = 15;

	// stage enables of one constant-divide unit
	typedef struct packed {
		logic en_a;
		logic en_b;
		logic en_c;
	} div_en_t;

	// 60-degree hue sectors
	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

endpackage

// ===== sv/hsv_if.sv =====
// ----------------------------------------------------------------------------
// hsv_if: request channels of the HSV to RGB converter
// One channel carries hue, saturation and brightness; the other red, green
// and blue. A request moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface hsv_color_if #(
	parameter int unsigned CHANNEL_BITS = 8
);
	logic                      valid;
	logic                      ready;
	logic [hsv_pkg::HUE_W-1:0] hue;
	logic [CHANNEL_BITS-1:0]   saturation;
	logic [CHANNEL_BITS-1:0]   brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

interface rgb_color_if #(
	parameter int unsigned CHANNEL_BITS = 8
);
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] red;
	logic [CHANNEL_BITS-1:0] green;
	logic [CHANNEL_BITS-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== sv/hsv_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// hsv_pipe_ctrl: valid bits and stage enables of the converter pipeline
// A stage loads when any stage at or after it is empty or the output drains.
// ----------------------------------------------------------------------------
module hsv_pipe_ctrl #(
	parameter int unsigned DEPTH = 14
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [DEPTH:1] en
);

	logic [DEPTH:1] valid_q;

	for (genvar k = 1; k <= DEPTH; k++) begin : g_stage
		// advance when a hole lies downstream or the output is taken
		assign en[k] = out_ready || !(&valid_q[DEPTH:k]);

		if (k == 1) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_q[k] <= 1'b0;
				end else if (en[k]) begin
					valid_q[k] <= in_valid;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_q[k] <= 1'b0;
				end else if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[1];
	assign out_valid = valid_q[DEPTH];

	// requests in flight change only by what enters and leaves
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> $countones(valid_q) == $past($countones(valid_q))
			+ int'($past(in_valid && en[1])) - int'($past(out_valid && out_ready)))
		else $error("pipeline request count out of balance");

	// a full stage never loads without its successor loading too
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		((en[DEPTH-1:1] & valid_q[DEPTH-1:1]) & ~en[DEPTH:2]) == '0)
		else $error("pipeline stage overwritten");

	// a waiting result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

endmodule

// ===== sv/hsv_cdiv.sv =====
// ----------------------------------------------------------------------------
// hsv_cdiv: three-stage divide by a constant
// Reciprocal multiply, back-multiply and subtract, then one correction step.
// ----------------------------------------------------------------------------
module hsv_cdiv #(
	parameter int unsigned      NW      = 16,
	parameter longint unsigned  DIVISOR = 3,
	parameter int unsigned      QW      = 8
) (
	input  logic              clk,
	input  hsv_pkg::div_en_t  en,
	input  logic [NW-1:0]     num,
	output logic [QW-1:0]     quot,
	output logic [NW-1:0]     rem
);

	localparam longint unsigned RECIP = (64'd1 << NW) / DIVISOR;
	localparam int unsigned     MW    = $clog2(RECIP + 1);
	localparam int unsigned     PW    = NW + MW;
	localparam logic [NW-1:0]   DIV_V   = NW'(DIVISOR);
	localparam logic [MW-1:0]   RECIP_V = MW'(RECIP);

	logic [NW-1:0] num_s1;
	logic [PW-1:0] prod_s1;
	logic [MW-1:0] quot_est;
	logic [NW-1:0] back_mul;
	logic [MW-1:0] quot_s2;
	logic [NW-1:0] rem_s2;
	logic [MW:0]   quot_inc;
	logic [QW-1:0] quot_s3;
	logic [NW-1:0] rem_s3;

	always_ff @(posedge clk) begin
		if (en.en_a) begin
			num_s1  <= num;
			prod_s1 <= PW'(num) * PW'(RECIP_V);
		end
	end

	// estimate is exact or one low
	assign quot_est = prod_s1[PW-1:NW];
	assign back_mul = NW'(NW'(quot_est) * DIV_V);

	always_ff @(posedge clk) begin
		if (en.en_b) begin
			quot_s2 <= quot_est;
			rem_s2  <= num_s1 - back_mul;
		end
	end

	assign quot_inc = {1'b0, quot_s2} + {{MW{1'b0}}, 1'b1};

	always_ff @(posedge clk) begin
		if (en.en_c) begin
			if (rem_s2 >= DIV_V) begin
				quot_s3 <= QW'(quot_inc);
				rem_s3  <= rem_s2 - DIV_V;
			end else begin
				quot_s3 <= QW'(quot_s2);
				rem_s3  <= rem_s2;
			end
		end
	end

	assign quot = quot_s3;
	assign rem  = rem_s3;

endmodule

// ===== sv/hsv_to_rgb_converter_core.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core: pipelined HSV to RGB color converter
// Wraps hue to one turn, finds its sector, forms p, q and t and routes them.
// ----------------------------------------------------------------------------
// Usage:
//   hsv carries one color request: hue in 1/HUE_STEPS_PER_DEGREE degree
//   steps (any 15-bit value, wrapped to one turn), saturation and brightness
//   as fractions where all ones means 1.0. rgb returns one request per input
//   with red, green and blue rounded half up to CHANNEL_BITS bits.
//   A request moves when valid and ready are both high.
//   The core has 14 register stages; throughput is one color per cycle while
//   rgb does not stall. No stage chains two multipliers; the depth is set by
//   three chained three-stage constant dividers (hue wrap, sector split,
//   term rounding) plus the product and sum stages between them and the
//   final routing stage.
//   Reset clears all valid bits; no payload register is reset and no
//   clearing pass is needed.
//   When rgb stalls, the last stage holds its result and earlier stages keep
//   filling any empty slots; hsv.ready drops only once every stage is full.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core #(
	parameter int unsigned HUE_STEPS_PER_DEGREE = 64,
	parameter int unsigned CHANNEL_BITS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	hsv_color_if.sink      hsv,
	rgb_color_if.source    rgb
);

	localparam int unsigned     CB     = CHANNEL_BITS;
	localparam int unsigned     HW     = hsv_pkg::HUE_W;
	localparam longint unsigned FS     = (64'd1 << CB) - 64'd1;
	localparam longint unsigned SECTOR = 64'd60 * HUE_STEPS_PER_DEGREE;
	localparam longint unsigned TURN   = 64'd6 * SECTOR;
	localparam longint unsigned FSD    = FS * SECTOR;
	localparam int unsigned     TW     = $clog2(TURN + 1);
	localparam int unsigned     HUE_NW = (TW > HW) ? TW : HW;
	localparam int unsigned     RW     = $clog2(SECTOR);
	localparam int unsigned     DRW    = $clog2(SECTOR + 1);
	localparam int unsigned     XW     = $clog2(FSD + 1);
	localparam int unsigned     SRW    = CB + RW;
	localparam int unsigned     SDW    = CB + DRW;
	localparam int unsigned     PPW    = 2 * CB;
	localparam int unsigned     QPW    = CB + XW;
	localparam int unsigned     NPW    = $clog2(64'd2 * FS * FS + FS + 1);
	localparam int unsigned     NQW    = $clog2(64'd2 * FS * FSD + FSD + 1);
	localparam int unsigned     DEPTH  = 14;

	localparam logic [CB-1:0]  FS_V     = CB'(FS);
	localparam logic [DRW-1:0] SECTOR_V = DRW'(SECTOR);
	localparam logic [XW-1:0]  FSD_V    = XW'(FSD);

	logic [DEPTH:1] en;

	hsv_pipe_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (hsv.valid),
		.in_ready (hsv.ready),
		.out_valid(rgb.valid),
		.out_ready(rgb.ready),
		.en       (en)
	);

	// side data travelling alongside the arithmetic
	logic [CB-1:0]      bright_s [1:13];
	logic [CB-1:0]      sat_s    [1:6];
	hsv_pkg::sector_t   sector_s [7:13];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			bright_s[1] <= hsv.brightness;
			sat_s[1]    <= hsv.saturation;
		end
	end

	for (genvar k = 2; k <= 13; k++) begin : g_bright
		always_ff @(posedge clk) begin
			if (en[k]) begin
				bright_s[k] <= bright_s[k-1];
			end
		end
	end

	for (genvar k = 2; k <= 6; k++) begin : g_sat
		always_ff @(posedge clk) begin
			if (en[k]) begin
				sat_s[k] <= sat_s[k-1];
			end
		end
	end

	for (genvar k = 8; k <= 13; k++) begin : g_sector
		always_ff @(posedge clk) begin
			if (en[k]) begin
				sector_s[k] <= sector_s[k-1];
			end
		end
	end

	// stages 1-3: wrap hue to one turn
	hsv_pkg::div_en_t  en_turn;
	logic [HUE_NW-1:0] turn_rem;

	assign en_turn = '{en_a: en[1], en_b: en[2], en_c: en[3]};

	hsv_cdiv #(
		.NW     (HUE_NW),
		.DIVISOR(TURN),
		.QW     (1)
	) u_turn_div (
		.clk (clk),
		.en  (en_turn),
		.num (HUE_NW'(hsv.hue)),
		.quot(),
		.rem (turn_rem)
	);

	// stages 4-6: split wrapped hue into sector and offset
	hsv_pkg::div_en_t en_sec;
	logic [2:0]       sector_quot;
	logic [HW-1:0]    sector_rem;
	logic [RW-1:0]    offset;

	assign en_sec = '{en_a: en[4], en_b: en[5], en_c: en[6]};

	hsv_cdiv #(
		.NW     (HW),
		.DIVISOR(SECTOR),
		.QW     (3)
	) u_sector_div (
		.clk (clk),
		.en  (en_sec),
		.num (turn_rem[HW-1:0]),
		.quot(sector_quot),
		.rem (sector_rem)
	);

	assign offset = sector_rem[RW-1:0];

	// stage 7: saturation products
	logic [DRW-1:0] offset_rest;
	logic [SRW-1:0] sr_s7;
	logic [SDW-1:0] sdr_s7;
	logic [PPW-1:0] pprod_s7;

	assign offset_rest = SECTOR_V - DRW'(offset);

	always_ff @(posedge clk) begin
		if (en[7]) begin
			sr_s7       <= SRW'(sat_s[6]) * SRW'(offset);
			sdr_s7      <= SDW'(sat_s[6]) * SDW'(offset_rest);
			pprod_s7    <= PPW'(bright_s[6]) * PPW'(FS_V - sat_s[6]);
			sector_s[7] <= hsv_pkg::sector_t'(sector_quot);
		end
	end

	// stage 8: q and t factors, rounded p numerator
	logic [XW-1:0]  xq_s8;
	logic [XW-1:0]  xt_s8;
	logic [NPW-1:0] np_s8;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			xq_s8 <= FSD_V - XW'(sr_s7);
			xt_s8 <= FSD_V - XW'(sdr_s7);
			np_s8 <= NPW'({pprod_s7, 1'b0}) + NPW'(FS_V);
		end
	end

	// stage 9: scale q and t factors by brightness
	logic [QPW-1:0] qprod_s9;
	logic [QPW-1:0] tprod_s9;
	logic [NPW-1:0] np_s9;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			qprod_s9 <= QPW'(bright_s[8]) * QPW'(xq_s8);
			tprod_s9 <= QPW'(bright_s[8]) * QPW'(xt_s8);
			np_s9    <= np_s8;
		end
	end

	// stage 10: add half the divisor for round half up
	logic [NQW-1:0] nq_s10;
	logic [NQW-1:0] nt_s10;
	logic [NPW-1:0] np_s10;

	always_ff @(posedge clk) begin
		if (en[10]) begin
			nq_s10 <= NQW'({qprod_s9, 1'b0}) + NQW'(FSD_V);
			nt_s10 <= NQW'({tprod_s9, 1'b0}) + NQW'(FSD_V);
			np_s10 <= np_s9;
		end
	end

	// stages 11-13: divide by twice the full-scale denominators
	hsv_pkg::div_en_t en_term;
	logic [CB-1:0]    p_term;
	logic [CB-1:0]    q_term;
	logic [CB-1:0]    t_term;

	assign en_term = '{en_a: en[11], en_b: en[12], en_c: en[13]};

	hsv_cdiv #(
		.NW     (NPW),
		.DIVISOR(64'd2 * FS),
		.QW     (CB)
	) u_p_div (
		.clk (clk),
		.en  (en_term),
		.num (np_s10),
		.quot(p_term),
		.rem ()
	);

	hsv_cdiv #(
		.NW     (NQW),
		.DIVISOR(64'd2 * FSD),
		.QW     (CB)
	) u_q_div (
		.clk (clk),
		.en  (en_term),
		.num (nq_s10),
		.quot(q_term),
		.rem ()
	);

	hsv_cdiv #(
		.NW     (NQW),
		.DIVISOR(64'd2 * FSD),
		.QW     (CB)
	) u_t_div (
		.clk (clk),
		.en  (en_term),
		.num (nt_s10),
		.quot(t_term),
		.rem ()
	);

	// stage 14: route terms to channels by sector
	logic [CB-1:0] red_d;
	logic [CB-1:0] green_d;
	logic [CB-1:0] blue_d;
	logic [CB-1:0] red_s14;
	logic [CB-1:0] green_s14;
	logic [CB-1:0] blue_s14;

	always_comb begin
		unique case (sector_s[13])
			hsv_pkg::SEC_RED_YEL: begin
				red_d   = bright_s[13];
				green_d = t_term;
				blue_d  = p_term;
			end
			hsv_pkg::SEC_YEL_GRN: begin
				red_d   = q_term;
				green_d = bright_s[13];
				blue_d  = p_term;
			end
			hsv_pkg::SEC_GRN_CYN: begin
				red_d   = p_term;
				green_d = bright_s[13];
				blue_d  = t_term;
			end
			hsv_pkg::SEC_CYN_BLU: begin
				red_d   = p_term;
				green_d = q_term;
				blue_d  = bright_s[13];
			end
			hsv_pkg::SEC_BLU_MAG: begin
				red_d   = t_term;
				green_d = p_term;
				blue_d  = bright_s[13];
			end
			default: begin
				red_d   = bright_s[13];
				green_d = p_term;
				blue_d  = q_term;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[14]) begin
			red_s14   <= red_d;
			green_s14 <= green_d;
			blue_s14  <= blue_d;
		end
	end

	assign rgb.red   = red_s14;
	assign rgb.green = green_s14;
	assign rgb.blue  = blue_s14;

endmodule

// ===== sim/hsv_to_rgb_converter_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_checker: color prediction and result check
// Watches both request channels. Predicts red, green and blue for every
// accepted color and compares each returned request with the oldest guess.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_checker #(
	parameter int unsigned HUE_STEPS_PER_DEGREE = 64,
	parameter int unsigned CHANNEL_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	hsv_color_if        hsv,
	rgb_color_if        rgb,
	output int unsigned failures,
	output int unsigned outstanding
);

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
	} rgb_color_t;

	rgb_color_t  expected_colors[$];
	int unsigned err_total = 0;

	// round num/den half up
	function automatic longint unsigned round_half_up(longint unsigned num,
		longint unsigned den);
		return (2 * num + den) / (2 * den);
	endfunction

	function automatic rgb_color_t convert_hsv(logic [hsv_pkg::HUE_W-1:0] hue,
		logic [CHANNEL_BITS-1:0] sat, logic [CHANNEL_BITS-1:0] bri);
		longint unsigned         full_scale, sector_steps, wrapped, rem, den, s, v;
		longint unsigned         p_term, q_term, t_term;
		logic [2:0]              sector_idx;
		hsv_pkg::sector_t        sector;
		logic [CHANNEL_BITS-1:0] v_c, p_c, q_c, t_c;
		rgb_color_t              c;
		full_scale   = (64'd1 << CHANNEL_BITS) - 1;
		sector_steps = 60 * HUE_STEPS_PER_DEGREE;
		wrapped      = longint'(hue) % (6 * sector_steps);
		sector_idx   = 3'(wrapped / sector_steps);
		sector       = hsv_pkg::sector_t'(sector_idx);
		rem          = wrapped % sector_steps;
		den          = full_scale * sector_steps;
		s            = sat;
		v            = bri;
		p_term = round_half_up(v * (full_scale - s), full_scale);
		q_term = round_half_up(v * (den - s * rem), den);
		t_term = round_half_up(v * (den - s * (sector_steps - rem)), den);
		// grey: every channel follows brightness
		if (s == 0) begin
			p_term = v;
			q_term = v;
			t_term = v;
		end
		v_c = CHANNEL_BITS'(v);
		p_c = CHANNEL_BITS'(p_term);
		q_c = CHANNEL_BITS'(q_term);
		t_c = CHANNEL_BITS'(t_term);
		case (sector)
			hsv_pkg::SEC_RED_YEL: c = '{v_c, t_c, p_c};
			hsv_pkg::SEC_YEL_GRN: c = '{q_c, v_c, p_c};
			hsv_pkg::SEC_GRN_CYN: c = '{p_c, v_c, t_c};
			hsv_pkg::SEC_CYN_BLU: c = '{p_c, q_c, v_c};
			hsv_pkg::SEC_BLU_MAG: c = '{t_c, p_c, v_c};
			default:              c = '{v_c, p_c, q_c};
		endcase
		return c;
	endfunction

	task automatic check_channel(string name, logic [CHANNEL_BITS-1:0] want,
		logic [CHANNEL_BITS-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			err_total++;
		end
	endtask

	always @(posedge clk) begin
		rgb_color_t want;
		if (arst_n) begin
			if (hsv.valid && hsv.ready)
				expected_colors.insert(expected_colors.size(),
					convert_hsv(hsv.hue, hsv.saturation, hsv.brightness));
			if (rgb.valid && rgb.ready) begin
				if (expected_colors.size() == 0) begin
					$error("unexpected rgb request: red %0d green %0d blue %0d",
						rgb.red, rgb.green, rgb.blue);
					err_total++;
				end else begin
					want = expected_colors.pop_front();
					check_channel("red", want.red, rgb.red);
					check_channel("green", want.green, rgb.green);
					check_channel("blue", want.blue, rgb.blue);
				end
			end
		end
		failures    <= err_total;
		outstanding <= expected_colors.size();
	end

endmodule

// ===== sim/hsv_to_rgb_converter_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core_tb: stimulus and verdict for the color converter
// Sends directed corner colors and then random ones with random gaps on the
// hsv side and random stalls on the rgb side. The checker beside the core
// predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core_tb;

	localparam int unsigned HUE_STEPS_PER_DEGREE = 64;
	localparam int unsigned CHANNEL_BITS         = 8;
	localparam int unsigned HUE_BITS             = hsv_pkg::HUE_W;
	localparam int unsigned SECTOR_STEPS         = 60 * HUE_STEPS_PER_DEGREE;
	localparam int unsigned RANDOM_REQUESTS      = 950;
	// pipeline depth plus margin for the drain after the last result
	localparam int unsigned TAIL_CYCLES          = 40;

	logic        clk = 1'b0;
	logic        arst_n;
	bit          no_idle = 1'b0;
	int unsigned failures;
	int unsigned outstanding;

	hsv_color_if #(.CHANNEL_BITS(CHANNEL_BITS)) hsv_bus ();
	rgb_color_if #(.CHANNEL_BITS(CHANNEL_BITS)) rgb_bus ();

	hsv_to_rgb_converter_core #(
		.HUE_STEPS_PER_DEGREE(HUE_STEPS_PER_DEGREE),
		.CHANNEL_BITS(CHANNEL_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.hsv(hsv_bus),
		.rgb(rgb_bus)
	);

	hsv_to_rgb_converter_checker #(
		.HUE_STEPS_PER_DEGREE(HUE_STEPS_PER_DEGREE),
		.CHANNEL_BITS(CHANNEL_BITS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.hsv(hsv_bus),
		.rgb(rgb_bus),
		.failures(failures),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Send one color request. Drop valid for a random gap first, unless in a
	// burst stretch, then hold the request until the core takes it.
	task automatic send_color(logic [HUE_BITS-1:0] hue,
		logic [CHANNEL_BITS-1:0] sat, logic [CHANNEL_BITS-1:0] bri);
		int unsigned gap;
		// flip between idling and back-to-back stretches now and then
		if ($urandom_range(39) == 0)
			no_idle = !no_idle;
		gap = no_idle ? 0 : $urandom_range(9);
		if (gap > 0) begin
			hsv_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hsv_bus.valid      <= 1'b1;
		hsv_bus.hue        <= hue;
		hsv_bus.saturation <= sat;
		hsv_bus.brightness <= bri;
		// sample ready as it stood before this edge
		do
			@(posedge clk);
		while (!hsv_bus.ready);
	endtask

	// Pick a fraction that lands on zero or full scale fairly often.
	function automatic logic [CHANNEL_BITS-1:0] pick_fraction();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return CHANNEL_BITS'($urandom);
		endcase
	endfunction

	// Pick a hue: mostly anywhere in the 15-bit field (past a full turn
	// too), sometimes right next to a sector boundary.
	function automatic logic [HUE_BITS-1:0] pick_hue();
		int signed edge_hue;
		if ($urandom_range(3) != 0)
			return HUE_BITS'($urandom);
		edge_hue = $urandom_range(8) * SECTOR_STEPS + $urandom_range(4) - 2;
		if (edge_hue < 0)
			edge_hue = 0;
		return HUE_BITS'(edge_hue);
	endfunction

	// Drive the result side: drop ready for a random stall before each request,
	// none in burst stretches, then hold ready until a request moves.
	initial begin
		int unsigned stall;
		rgb_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_idle ? 0 : $urandom_range(9);
			if (stall > 0) begin
				rgb_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rgb_bus.ready <= 1'b1;
			do
				@(posedge clk);
			while (!rgb_bus.valid);
		end
	end

	// Main sequence: reset, directed colors, random colors, drain, verdict.
	initial begin
		arst_n = 1'b0;
		hsv_bus.valid      <= 1'b0;
		hsv_bus.hue        <= '0;
		hsv_bus.saturation <= '0;
		hsv_bus.brightness <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// black, white grey, pure red
		send_color(15'd0, 8'd0, 8'd0);
		send_color(15'd0, 8'd0, 8'd255);
		send_color(15'd0, 8'd255, 8'd255);
		// hue extremes: largest field value, just under a turn, exactly a turn
		send_color(15'h7fff, 8'd255, 8'd255);
		send_color(15'd23039, 8'd255, 8'd255);
		send_color(15'd23040, 8'd255, 8'd255);
		// both sides of each boundary between neighbouring sectors
		for (int k = 1; k < 6; k++) begin
			send_color(HUE_BITS'(k * SECTOR_STEPS), 8'd255, 8'd255);
			send_color(HUE_BITS'(k * SECTOR_STEPS - 1), 8'd255, 8'd255);
		end
		// mid sector, weak saturation, weak brightness
		send_color(15'd1920, 8'd128, 8'd200);
		send_color(15'd13000, 8'd1, 8'd255);
		send_color(15'd5000, 8'd255, 8'd1);
		// grey on a hue past a full turn
		send_color(15'd30000, 8'd0, 8'd77);
		// alternating bit patterns
		send_color(15'd10000, 8'haa, 8'h55);
		send_color(15'h5555, 8'h55, 8'haa);
		// wrapped hues landing in the first and second sectors
		send_color(15'd26000, 8'd200, 8'd255);
		send_color(15'd27000, 8'd128, 8'd128);

		for (int i = 0; i < RANDOM_REQUESTS; i++)
			send_color(pick_hue(), pick_fraction(), pick_fraction());
		hsv_bus.valid <= 1'b0;

		// let the checker register the last request before polling it
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (failures == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog: the slowest correct run is well under a tenth of this.
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== hsv_to_rgb_converter_core.f =====
sv/hsv_pkg.sv
sv/hsv_if.sv
sv/hsv_pipe_ctrl.sv
sv/hsv_cdiv.sv
sv/hsv_to_rgb_converter_core.sv
sim/hsv_to_rgb_converter_checker.sv
sim/hsv_to_rgb_converter_core_tb.sv
